// ----- hdl/cau_pkg.sv -----
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

   // Fixed-point format of operands and results.
   localparam int FRAC_BITS    = 16;
   // Number of CORDIC micro-rotations used for the angle (at most 32).
   localparam int CORDIC_STEPS = 24;
   // Fraction bits of the internal angle accumulator (degrees).
   localparam int ANG_FRAC     = 24;
   // One divider bit and one square-root bit are resolved per stage.
   localparam int ITER_STAGES  = 32;
   localparam int ITER_W       = $clog2(ITER_STAGES);
   // Front end has three stages, the back end one.
   localparam int LATENCY      = 3 + ITER_STAGES + 1;

   localparam logic signed [33:0] ANG_90  = 34'sd1509949440;
   localparam logic signed [33:0] ANG_180 = 34'sd3019898880;

   // Operation codes.
   localparam logic [2:0] MODE_ADD   = 3'd0;
   localparam logic [2:0] MODE_SUB   = 3'd1;
   localparam logic [2:0] MODE_MUL   = 3'd2;
   localparam logic [2:0] MODE_DIV   = 3'd3;
   localparam logic [2:0] MODE_MAG   = 3'd4;
   localparam logic [2:0] MODE_ANGLE = 3'd5;
   localparam logic [2:0] MODE_EQUAL = 3'd6;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic               is_equal;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] val;
   } pack_type;

   // Everything one item carries through the iterative stages.
   typedef struct packed {
      logic               valid;
      logic [2:0]         mode;
      logic [31:0]        e_re;
      logic [31:0]        e_im;
      logic               e_eq;
      logic               e_sat;
      logic [63:0]        den;
      logic [63:0]        r_re;
      logic [63:0]        r_im;
      logic [31:0]        w_re;
      logic [31:0]        w_im;
      logic               neg_re;
      logic               neg_im;
      logic               ovf_re;
      logic               ovf_im;
      logic               dz;
      logic [63:0]        rad;
      logic [33:0]        rem;
      logic [31:0]        root;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [33:0] z;
      logic               azero;
   } stage_type;

   // Sign and magnitude to a saturated 32-bit two's complement word.
   function automatic pack_type pack_mag(input logic [63:0] mag, input logic neg);
      pack_type p;
      p.sat = 1'b0;
      if (neg) begin
         if (mag > 64'h0000_0000_8000_0000) begin
            p.sat = 1'b1;
            p.val = 32'h8000_0000;
         end else begin
            p.val = 32'(~mag + 64'd1);
         end
      end else begin
         if (mag > 64'h0000_0000_7FFF_FFFF) begin
            p.sat = 1'b1;
            p.val = 32'h7FFF_FFFF;
         end else begin
            p.val = mag[31:0];
         end
      end
      return p;
   endfunction

   // Arc tangent of 2^-idx in degrees, scaled by 2^24.
   function automatic logic [29:0] atan_deg(input logic [4:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:  v = 30'd754974720;
         5'd1:  v = 30'd445687602;
         5'd2:  v = 30'd235489088;
         5'd3:  v = 30'd119537938;
         5'd4:  v = 30'd60000934;
         5'd5:  v = 30'd30029717;
         5'd6:  v = 30'd15018523;
         5'd7:  v = 30'd7509720;
         5'd8:  v = 30'd3754917;
         5'd9:  v = 30'd1877466;
         5'd10: v = 30'd938734;
         5'd11: v = 30'd469367;
         5'd12: v = 30'd234684;
         5'd13: v = 30'd117342;
         5'd14: v = 30'd58671;
         5'd15: v = 30'd29335;
         5'd16: v = 30'd14668;
         5'd17: v = 30'd7334;
         5'd18: v = 30'd3667;
         5'd19: v = 30'd1833;
         5'd20: v = 30'd917;
         5'd21: v = 30'd458;
         5'd22: v = 30'd229;
         5'd23: v = 30'd115;
         5'd24: v = 30'd57;
         5'd25: v = 30'd29;
         5'd26: v = 30'd14;
         5'd27: v = 30'd7;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/complex_arithmetic_unit_top.sv -----
// Top level of the complex arithmetic unit.
//
// A request transaction is taken at a rising edge where start is high and
// busy is low. busy stays low: the pipeline takes one transaction in every
// cycle. The payload carries the operation code and the two Q16.16 operands.
// Each response transaction appears on rsp_payload for exactly one cycle with
// rsp_strobe high, after three front-end stages (products, sums, set-up),
// 32 iterative stages that each resolve one quotient bit and one root bit
// (the first CORDIC_STEPS also one CORDIC rotation) and one packing stage.
// The 32 stages come from the 32-bit quotient and root width.
// Responses leave in request order at one per cycle; the receiver cannot hold
// them off, so nothing ever waits inside the block.
// Reset clears all valid bits: transactions in flight are dropped and no
// response appears until new requests reach the output.
module complex_arithmetic_unit_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cau_pkg::req_type  req_payload,
   output logic              rsp_strobe,
   output cau_pkg::rsp_type  rsp_payload
);

   cau_pkg::stage_type front_stage, iter_stage;

   // The pipeline never stalls.
   assign busy = 1'b0;

   cau_front u_front (
      .clock   (clock),
      .reset   (reset),
      .valid_i (start),
      .req_i   (req_payload),
      .stage_o (front_stage)
   );

   cau_iter u_iter (
      .clock   (clock),
      .reset   (reset),
      .stage_i (front_stage),
      .stage_o (iter_stage)
   );

   cau_back u_back (
      .clock    (clock),
      .reset    (reset),
      .stage_i  (iter_stage),
      .rsp_o    (rsp_payload),
      .strobe_o (rsp_strobe)
   );

   // Every accepted transaction gives a response after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(cau_pkg::LATENCY) rsp_strobe)
      else $error("response missing after request");

   // No response without a request the latency before.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, cau_pkg::LATENCY))
      else $error("response without request");

   // A zero divisor returns zero parts.
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == cau_pkg::ST_DIV_ZERO) |->
         (rsp_payload.res_re == 32'sd0 && rsp_payload.res_im == 32'sd0))
      else $error("division by zero with nonzero result");

   // An equality flag comes with a clean, zero result.
   a_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.is_equal) |->
         (rsp_payload.status == cau_pkg::ST_OK && rsp_payload.res_re == 32'sd0 &&
          rsp_payload.res_im == 32'sd0))
      else $error("equality flag with result or status");

endmodule

// ----- hdl/cau_front.sv -----
// Front end: operand products, sums, and set-up of divider, square root and CORDIC.
module cau_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_i,
   input  cau_pkg::req_type    req_i,
   output cau_pkg::stage_type  stage_o
);

   typedef struct packed {
      logic               valid;
      logic [2:0]         mode;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [31:0] br;
      logic signed [31:0] bi;
      logic signed [63:0] p_rr;
      logic signed [63:0] p_ii;
      logic signed [63:0] p_ri;
      logic signed [63:0] p_ir;
      logic signed [63:0] s_u;
      logic signed [63:0] s_v;
   } mul_type;

   typedef struct packed {
      logic               valid;
      logic [2:0]         mode;
      logic signed [31:0] ar;
      logic signed [31:0] ai;
      logic signed [64:0] v_re;
      logic signed [64:0] v_im;
      logic [63:0]        sq;
      logic signed [32:0] s_re;
      logic signed [32:0] s_im;
      logic               eq;
   } sum_type;

   mul_type            ma_in, ma_ff;
   sum_type            sb_in, sb_ff;
   cau_pkg::stage_type sc_in, sc_ff;

   logic signed [31:0] sq_u, sq_v;
   logic [63:0]        mag_re, mag_im;
   logic [63:0]        smag_re, smag_im;
   logic [63:0]        r0_re, r0_im;
   logic signed [63:0] x0, y0;
   cau_pkg::pack_type  pk_re, pk_im;

   // Stage one: all products the operations need.
   always_comb begin
      sq_u = (req_i.mode == cau_pkg::MODE_MAG) ? req_i.a_re : req_i.b_re;
      sq_v = (req_i.mode == cau_pkg::MODE_MAG) ? req_i.a_im : req_i.b_im;
      ma_in.valid = valid_i;
      ma_in.mode  = req_i.mode;
      ma_in.ar    = req_i.a_re;
      ma_in.ai    = req_i.a_im;
      ma_in.br    = req_i.b_re;
      ma_in.bi    = req_i.b_im;
      ma_in.p_rr  = req_i.a_re * req_i.b_re;
      ma_in.p_ii  = req_i.a_im * req_i.b_im;
      ma_in.p_ri  = req_i.a_re * req_i.b_im;
      ma_in.p_ir  = req_i.a_im * req_i.b_re;
      ma_in.s_u   = sq_u * sq_u;
      ma_in.s_v   = sq_v * sq_v;
   end

   // Stage two: cross-product sums, squared norm, plain sums and equality.
   always_comb begin
      sb_in.valid = ma_ff.valid;
      sb_in.mode  = ma_ff.mode;
      sb_in.ar    = ma_ff.ar;
      sb_in.ai    = ma_ff.ai;
      if (ma_ff.mode == cau_pkg::MODE_DIV) begin
         sb_in.v_re = 65'(ma_ff.p_rr) + 65'(ma_ff.p_ii);
         sb_in.v_im = 65'(ma_ff.p_ir) - 65'(ma_ff.p_ri);
      end else begin
         sb_in.v_re = 65'(ma_ff.p_rr) - 65'(ma_ff.p_ii);
         sb_in.v_im = 65'(ma_ff.p_ri) + 65'(ma_ff.p_ir);
      end
      sb_in.sq = $unsigned(ma_ff.s_u) + $unsigned(ma_ff.s_v);
      if (ma_ff.mode == cau_pkg::MODE_SUB) begin
         sb_in.s_re = 33'(ma_ff.ar) - 33'(ma_ff.br);
         sb_in.s_im = 33'(ma_ff.ai) - 33'(ma_ff.bi);
      end else begin
         sb_in.s_re = 33'(ma_ff.ar) + 33'(ma_ff.br);
         sb_in.s_im = 33'(ma_ff.ai) + 33'(ma_ff.bi);
      end
      sb_in.eq = (ma_ff.ar == ma_ff.br) && (ma_ff.ai == ma_ff.bi);
   end

   // Stage three: magnitudes, early results and initial iteration state.
   always_comb begin
      mag_re  = sb_ff.v_re[64] ? 64'(-sb_ff.v_re) : sb_ff.v_re[63:0];
      mag_im  = sb_ff.v_im[64] ? 64'(-sb_ff.v_im) : sb_ff.v_im[63:0];
      smag_re = sb_ff.s_re[32] ? 64'($unsigned(-sb_ff.s_re)) : 64'($unsigned(sb_ff.s_re));
      smag_im = sb_ff.s_im[32] ? 64'($unsigned(-sb_ff.s_im)) : 64'($unsigned(sb_ff.s_im));
      r0_re   = mag_re >> (32 - cau_pkg::FRAC_BITS);
      r0_im   = mag_im >> (32 - cau_pkg::FRAC_BITS);
      pk_re   = '0;
      pk_im   = '0;

      sc_in       = '0;
      sc_in.valid = sb_ff.valid;
      sc_in.mode  = sb_ff.mode;

      // Results that need no iteration.
      unique case (sb_ff.mode)
         cau_pkg::MODE_ADD, cau_pkg::MODE_SUB: begin
            pk_re = cau_pkg::pack_mag(smag_re, sb_ff.s_re[32]);
            pk_im = cau_pkg::pack_mag(smag_im, sb_ff.s_im[32]);
         end
         cau_pkg::MODE_MUL: begin
            pk_re = cau_pkg::pack_mag(mag_re >> cau_pkg::FRAC_BITS, sb_ff.v_re[64]);
            pk_im = cau_pkg::pack_mag(mag_im >> cau_pkg::FRAC_BITS, sb_ff.v_im[64]);
         end
         cau_pkg::MODE_EQUAL: begin
            sc_in.e_eq = sb_ff.eq;
         end
         default: begin
            pk_re = '0;
         end
      endcase
      sc_in.e_re  = pk_re.val;
      sc_in.e_im  = pk_im.val;
      sc_in.e_sat = pk_re.sat | pk_im.sat;

      // Divider: the quotient fits 32 bits unless the top part reaches the divisor.
      sc_in.den    = sb_ff.sq;
      sc_in.dz     = (sb_ff.sq == 64'd0);
      sc_in.r_re   = r0_re;
      sc_in.r_im   = r0_im;
      sc_in.ovf_re = (r0_re >= sb_ff.sq);
      sc_in.ovf_im = (r0_im >= sb_ff.sq);
      sc_in.w_re   = mag_re[31:0] << cau_pkg::FRAC_BITS;
      sc_in.w_im   = mag_im[31:0] << cau_pkg::FRAC_BITS;
      sc_in.neg_re = sb_ff.v_re[64];
      sc_in.neg_im = sb_ff.v_im[64];

      // Square root of the squared magnitude.
      sc_in.rad  = sb_ff.sq;
      sc_in.rem  = '0;
      sc_in.root = '0;

      // CORDIC: vectors in the left half-plane are turned by a quarter first.
      x0 = 64'(sb_ff.ar) <<< cau_pkg::ANG_FRAC;
      y0 = 64'(sb_ff.ai) <<< cau_pkg::ANG_FRAC;
      sc_in.azero = (sb_ff.ar == 32'sd0) && (sb_ff.ai == 32'sd0);
      if (sb_ff.ar[31]) begin
         if (!sb_ff.ai[31]) begin
            sc_in.x = y0;
            sc_in.y = -x0;
            sc_in.z = cau_pkg::ANG_90;
         end else begin
            sc_in.x = -y0;
            sc_in.y = x0;
            sc_in.z = -cau_pkg::ANG_90;
         end
      end else begin
         sc_in.x = x0;
         sc_in.y = y0;
         sc_in.z = '0;
      end
   end

   // Pipeline registers, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ma_ff <= '0;
         sb_ff <= '0;
         sc_ff <= '0;
      end else begin
         ma_ff <= ma_in;
         sb_ff <= sb_in;
         sc_ff <= sc_in;
      end
   end

   assign stage_o = sc_ff;

endmodule

// ----- hdl/cau_iter.sv -----
// Iterative stages: a quotient bit, a root bit; the first CORDIC_STEPS also rotate.
module cau_iter (
   input  logic                clock,
   input  logic                reset,
   input  cau_pkg::stage_type  stage_i,
   output cau_pkg::stage_type  stage_o
);

   cau_pkg::stage_type stg_in [cau_pkg::ITER_STAGES];
   cau_pkg::stage_type stg_ff [cau_pkg::ITER_STAGES];

   // Work of one stage; idx is fixed for each stage.
   function automatic cau_pkg::stage_type step(input cau_pkg::stage_type cur,
                                               input logic [cau_pkg::ITER_W-1:0] idx);
      cau_pkg::stage_type nxt;
      logic [64:0]        rx_re, rx_im;
      logic               qb_re, qb_im;
      logic [35:0]        sx, st;
      logic signed [63:0] dx, dy;
      logic signed [33:0] at;
      nxt   = cur;
      // Restoring division, real and imaginary quotient.
      rx_re = {cur.r_re, cur.w_re[31]};
      qb_re = (rx_re >= {1'b0, cur.den});
      if (qb_re) begin
         rx_re = rx_re - {1'b0, cur.den};
      end
      nxt.r_re = rx_re[63:0];
      nxt.w_re = {cur.w_re[30:0], qb_re};
      rx_im = {cur.r_im, cur.w_im[31]};
      qb_im = (rx_im >= {1'b0, cur.den});
      if (qb_im) begin
         rx_im = rx_im - {1'b0, cur.den};
      end
      nxt.r_im = rx_im[63:0];
      nxt.w_im = {cur.w_im[30:0], qb_im};
      // Digit-by-digit square root, two radicand bits a stage.
      sx = {cur.rem, cur.rad[63:62]};
      st = {2'b00, cur.root, 2'b01};
      if (sx >= st) begin
         sx       = sx - st;
         nxt.root = {cur.root[30:0], 1'b1};
      end else begin
         nxt.root = {cur.root[30:0], 1'b0};
      end
      nxt.rem = sx[33:0];
      nxt.rad = {cur.rad[61:0], 2'b00};
      // CORDIC vectoring rotation.
      if (32'(idx) < cau_pkg::CORDIC_STEPS) begin
         dx = cur.y >>> idx;
         dy = cur.x >>> idx;
         at = $signed({4'b0000, cau_pkg::atan_deg(5'(idx))});
         if (cur.y > 64'sd0) begin
            nxt.x = cur.x + dx;
            nxt.y = cur.y - dy;
            nxt.z = cur.z + at;
         end else begin
            nxt.x = cur.x - dx;
            nxt.y = cur.y + dy;
            nxt.z = cur.z - at;
         end
      end
      return nxt;
   endfunction

   // Chain of stages, each registered.
   for (genvar g = 0; g < cau_pkg::ITER_STAGES; g++) begin : g_stage
      if (g == 0) begin : g_first
         assign stg_in[g] = step(stage_i, cau_pkg::ITER_W'(g));
      end else begin : g_next
         assign stg_in[g] = step(stg_ff[g-1], cau_pkg::ITER_W'(g));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[g] <= '0;
         end else begin
            stg_ff[g] <= stg_in[g];
         end
      end
   end

   assign stage_o = stg_ff[cau_pkg::ITER_STAGES-1];

endmodule

// ----- hdl/cau_back.sv -----
// Back end: packing of quotient, root and angle, and the result register.
module cau_back (
   input  logic                clock,
   input  logic                reset,
   input  cau_pkg::stage_type  stage_i,
   output cau_pkg::rsp_type    rsp_o,
   output logic                strobe_o
);

   cau_pkg::rsp_type  rsp_in, rsp_ff;
   logic              strobe_in, strobe_ff;
   cau_pkg::pack_type p_dre, p_dim, p_sq, p_ang;
   logic signed [33:0] zc;
   logic [33:0]        zmag;

   // Final packing and selection by operation.
   always_comb begin
      p_dre = cau_pkg::pack_mag(stage_i.ovf_re ? 64'hFFFF_FFFF_FFFF_FFFF
                                               : {32'd0, stage_i.w_re}, stage_i.neg_re);
      p_dim = cau_pkg::pack_mag(stage_i.ovf_im ? 64'hFFFF_FFFF_FFFF_FFFF
                                               : {32'd0, stage_i.w_im}, stage_i.neg_im);
      p_sq  = cau_pkg::pack_mag({32'd0, stage_i.root}, 1'b0);

      // The angle is clamped to a half turn either way.
      if (stage_i.azero) begin
         zc = '0;
      end else if (stage_i.z > cau_pkg::ANG_180) begin
         zc = cau_pkg::ANG_180;
      end else if (stage_i.z < -cau_pkg::ANG_180) begin
         zc = -cau_pkg::ANG_180;
      end else begin
         zc = stage_i.z;
      end
      zmag  = zc[33] ? $unsigned(-zc) : $unsigned(zc);
      p_ang = cau_pkg::pack_mag(64'(zmag >> (cau_pkg::ANG_FRAC - cau_pkg::FRAC_BITS)), zc[33]);

      strobe_in = stage_i.valid;
      rsp_in    = '0;
      unique case (stage_i.mode)
         cau_pkg::MODE_DIV: begin
            if (stage_i.dz) begin
               rsp_in.status = cau_pkg::ST_DIV_ZERO;
            end else begin
               rsp_in.res_re = p_dre.val;
               rsp_in.res_im = p_dim.val;
               rsp_in.status = (p_dre.sat | p_dim.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
         end
         cau_pkg::MODE_MAG: begin
            rsp_in.res_re = p_sq.val;
            rsp_in.status = p_sq.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
         end
         cau_pkg::MODE_ANGLE: begin
            rsp_in.res_re = p_ang.val;
            rsp_in.status = p_ang.sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
         end
         default: begin
            rsp_in.res_re   = stage_i.e_re;
            rsp_in.res_im   = stage_i.e_im;
            rsp_in.is_equal = stage_i.e_eq;
            rsp_in.status   = stage_i.e_sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
         end
      endcase
   end

   // Result register; the strobe is cleared by reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_o    = rsp_ff;
   assign strobe_o = strobe_ff;

endmodule
